FILE: design/class_bucketed_moving_average_defines.svh
// assertion macros for the class bucketed moving average checker
// expects clk and rst_n in the scope of each use
`ifndef CLASS_BUCKETED_MOVING_AVERAGE_DEFINES_SVH
`define CLASS_BUCKETED_MOVING_AVERAGE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define CBMA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define CBMA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/cbma_pkg.sv
// shared constants, types and the class mapping for the moving average block
// no dependencies
package cbma_pkg;

    localparam int WINDOW_LEN  = 10;
    localparam int CLASS_COUNT = 13;
    localparam int TIME_W      = 32;
    localparam int PRIO_W      = 16;
    localparam int MIN_W       = 16;
    localparam logic [MIN_W-1:0] MIN_RESET = 16'd5;

    localparam int CLS_W      = $clog2(CLASS_COUNT);
    localparam int POS_W      = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int SUM_W      = TIME_W + $clog2(WINDOW_LEN);
    localparam int MAG_W      = SUM_W;
    localparam int HALF_W     = (MAG_W + 1) / 2;
    localparam int RECIP_W    = MAG_W + 1;
    localparam int MUL_W      = HALF_W + RECIP_W;
    localparam int PROD_W     = MAG_W + RECIP_W;
    localparam int DIV_SHIFT  = MAG_W + $clog2(WINDOW_LEN);
    localparam int DIV_STEPS  = 2;
    localparam int STEP_W     = $clog2(DIV_STEPS);
    localparam int WIN_DEPTH  = CLASS_COUNT * WINDOW_LEN;
    localparam int ADDR_W     = $clog2(WIN_DEPTH);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int SINGLE_CLASSES = 5;
    localparam int BOUND_COUNT = 8;

    // rounded-up reciprocal of the window length, exact for any sum magnitude
    localparam logic [RECIP_W-1:0] DIV_RECIP = RECIP_W'(
        ((64'd1 << DIV_SHIFT) + 64'(WINDOW_LEN - 1)) / 64'(WINDOW_LEN));

    localparam logic [PRIO_W-1:0] CLASS_BOUNDS [BOUND_COUNT] = '{
        16'd5, 16'd101, 16'd700, 16'd800, 16'd900, 16'd1000, 16'd2000, 16'd10000
    };

    typedef enum logic {
        FUNC_RECORD   = 1'b0,
        FUNC_ESTIMATE = 1'b1
    } func_t;

    typedef struct packed {
        func_t                    func;
        logic [CLS_W-1:0]         cls;
        logic signed [TIME_W-1:0] diff;
    } work_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WRITE,
        ST_DIVIDE,
        ST_FINISH
    } back_state_t;

    function automatic logic [CLS_W-1:0] class_of(input logic [PRIO_W-1:0] prio);
        logic [CLS_W-1:0] cls;
        cls = CLS_W'(CLASS_COUNT - 1);
        for (int k = BOUND_COUNT - 1; k >= 1; k--)
        begin
            if (prio < CLASS_BOUNDS[k])
            begin
                cls = CLS_W'(SINGLE_CLASSES - 1 + k);
            end
        end
        if (prio < CLASS_BOUNDS[0])
        begin
            cls = prio[CLS_W-1:0];
        end
        return cls;
    endfunction

endpackage

FILE: design/cbma_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module cbma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/cbma_front.sv
// front end: classifies incoming requests and buffers them in a short queue
// depends on cbma_pkg
module cbma_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        func,
    input  logic [cbma_pkg::PRIO_W-1:0] priority_req,
    input  logic [cbma_pkg::TIME_W-1:0] now_time,
    input  logic [cbma_pkg::TIME_W-1:0] received_time,
    output logic                        head_valid,
    output cbma_pkg::work_item_t        head,
    input  logic                        pop
);
    import cbma_pkg::*;

    work_item_t        q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;
    work_item_t        item;
    logic              push;
    logic              do_pop;

    // classify and take the elapsed time
    always_comb
    begin
        item.func = func_t'(func);
        item.cls  = class_of(priority_req);
        item.diff = now_time - received_time;
    end

    assign in_stall   = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign push       = in_valid && !in_stall;
    assign head_valid = (cnt_reg != '0);
    assign do_pop     = pop && head_valid;
    assign head       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

FILE: design/cbma_back.sv
// back end: per-class window update with running sums and the reciprocal-multiply divide
// depends on cbma_pkg and cbma_ram
module cbma_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              head_valid,
    input  cbma_pkg::work_item_t              head,
    output logic                              pop,
    input  logic [cbma_pkg::MIN_W-1:0]        min_estimate,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [cbma_pkg::TIME_W-1:0] estimate
);
    import cbma_pkg::*;

    back_state_t              state_reg;
    back_state_t              state_next;
    logic signed [SUM_W-1:0]  sum_reg [CLASS_COUNT];
    logic [POS_W-1:0]         pos_reg [CLASS_COUNT];
    logic [WIN_DEPTH-1:0]     vld_reg;
    logic [STEP_W-1:0]        step_reg;
    logic                     out_valid_reg;
    logic signed [TIME_W-1:0] out_data_reg;
    logic [CLS_W-1:0]         cls_reg;
    logic signed [TIME_W-1:0] diff_reg;
    logic [ADDR_W-1:0]        addr_reg;
    logic                     old_vld_reg;
    logic [MAG_W-1:0]         mag_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic                     neg_reg;

    logic                     ram_re;
    logic                     ram_we;
    logic                     div_start;
    logic                     out_load;
    logic                     out_free;
    logic [ADDR_W-1:0]        rd_addr;
    logic [POS_W-1:0]         pos_sel;
    logic [POS_W-1:0]         pos_wrap;
    logic signed [SUM_W-1:0]  sum_sel;
    logic [SUM_W-1:0]         sum_abs;
    logic [TIME_W-1:0]        ram_rdata;
    logic signed [TIME_W-1:0] old_val;
    logic signed [SUM_W-1:0]  sum_upd;
    logic [HALF_W-1:0]        mul_op;
    logic [MUL_W-1:0]         mul_out;
    logic signed [TIME_W-1:0] q_signed;
    logic signed [TIME_W-1:0] result;

    cbma_ram #(
        .WIDTH(TIME_W),
        .DEPTH(WIN_DEPTH)
    ) u_window_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (diff_reg),
        .re    (ram_re),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    assign out_free = !out_valid_reg || !out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    state_next = (head.func == FUNC_ESTIMATE) ? ST_DIVIDE : ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                state_next = ST_IDLE;
            end
            ST_DIVIDE:
            begin
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        pop       = 1'b0;
        ram_we    = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            ST_IDLE:   pop      = head_valid;
            ST_WRITE:  ram_we   = 1'b1;
            ST_DIVIDE: pop      = 1'b0;
            ST_FINISH: out_load = out_free;
            default:   pop      = 1'b0;
        endcase
        ram_re    = pop && (head.func == FUNC_RECORD);
        div_start = pop && (head.func == FUNC_ESTIMATE);
    end

    // window address and running sum of the head's class
    always_comb
    begin
        pos_sel  = pos_reg[head.cls];
        pos_wrap = (pos_sel == POS_W'(WINDOW_LEN - 1)) ? '0 : pos_sel + 1'b1;
        rd_addr  = ADDR_W'(head.cls) * ADDR_W'(WINDOW_LEN) + ADDR_W'(pos_sel);
        sum_sel  = sum_reg[head.cls];
        sum_abs  = sum_sel[SUM_W-1] ? (~sum_sel + 1'b1) : sum_sel;
        old_val  = old_vld_reg ? $signed(ram_rdata) : '0;
        sum_upd  = sum_reg[cls_reg] - SUM_W'(old_val) + SUM_W'(diff_reg);
    end

    // reciprocal multiply, low half of the magnitude first
    always_comb
    begin
        mul_op  = (step_reg == '0) ? mag_reg[HALF_W-1:0] : HALF_W'(mag_reg[MAG_W-1:HALF_W]);
        mul_out = MUL_W'(mul_op) * MUL_W'(DIV_RECIP);
    end

    // sign and floor
    always_comb
    begin
        q_signed = prod_reg[DIV_SHIFT +: TIME_W];
        result   = neg_reg ? -q_signed : q_signed;
        if (result < $signed({{(TIME_W - MIN_W){1'b0}}, min_estimate}))
        begin
            result = $signed({{(TIME_W - MIN_W){1'b0}}, min_estimate});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            vld_reg       <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CLASS_COUNT; i++)
            begin
                sum_reg[i] <= '0;
                pos_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (ram_re)
            begin
                pos_reg[head.cls] <= pos_wrap;
            end
            if (ram_we)
            begin
                sum_reg[cls_reg]  <= sum_upd;
                vld_reg[addr_reg] <= 1'b1;
            end
            if (div_start)
            begin
                step_reg <= '0;
            end
            else if (state_reg == ST_DIVIDE)
            begin
                step_reg <= step_reg + 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_re)
        begin
            cls_reg     <= head.cls;
            diff_reg    <= head.diff;
            addr_reg    <= rd_addr;
            old_vld_reg <= vld_reg[rd_addr];
        end
        if (div_start)
        begin
            mag_reg <= MAG_W'(sum_abs);
            neg_reg <= sum_sel[SUM_W-1];
        end
        else if (state_reg == ST_DIVIDE)
        begin
            if (step_reg == '0)
            begin
                prod_reg <= PROD_W'(mul_out);
            end
            else
            begin
                prod_reg <= prod_reg + (PROD_W'(mul_out) << HALF_W);
            end
        end
        if (out_load)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign estimate  = out_data_reg;

endmodule

FILE: design/class_bucketed_moving_average.sv
// Per-class moving average of request times: 13 priority classes, a ring of
// the last ten elapsed times for each, and an estimate request returning the
// class average floored at min_estimate.
// Input channel: in_valid / in_stall with func, priority_req, now_time and
// received_time. func 0 records now_time - received_time into the class ring
// and gives no result; func 1 gives one estimate on the output channel.
// Output channel: out_valid / out_stall with estimate, held from a register.
// Config: cfg_we writes cfg_data into min_estimate (reset 5).
// A two-entry queue takes requests while the back end works. A record holds
// the back end for a window ram read, then write and running sum update.
// An estimate holds it to issue, for the reciprocal multiply of the 36-bit
// running sum magnitude (low half first) and to load the output register.
// While the receiver stalls, the result is held, the back end waits in its
// final step and the queue keeps taking requests until full.
// Reset clears the rings (per-entry valid bits), positions, sums and control.
// depends on cbma_pkg, cbma_front, cbma_back
module class_bucketed_moving_average (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               func,
    input  logic [cbma_pkg::PRIO_W-1:0]        priority_req,
    input  logic [cbma_pkg::TIME_W-1:0]        now_time,
    input  logic [cbma_pkg::TIME_W-1:0]        received_time,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [cbma_pkg::TIME_W-1:0] estimate,
    input  logic                               cfg_we,
    input  logic [cbma_pkg::MIN_W-1:0]         cfg_data
);
    import cbma_pkg::*;

    logic [MIN_W-1:0] min_estimate_reg;
    logic             head_valid;
    work_item_t       head;
    logic             pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_estimate_reg <= MIN_RESET;
        end
        else if (cfg_we)
        begin
            min_estimate_reg <= cfg_data;
        end
    end

    cbma_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .priority_req  (priority_req),
        .now_time      (now_time),
        .received_time (received_time),
        .head_valid    (head_valid),
        .head          (head),
        .pop           (pop)
    );

    cbma_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .min_estimate (min_estimate_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .estimate     (estimate)
    );

endmodule

FILE: design/cbma_checker.sv
// port-level checker for class_bucketed_moving_average, bound to the top level
// depends on cbma_pkg and class_bucketed_moving_average_defines.svh
`include "class_bucketed_moving_average_defines.svh"

module cbma_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_stall,
    input logic                               func,
    input logic                               out_valid,
    input logic                               out_stall,
    input logic signed [cbma_pkg::TIME_W-1:0] estimate,
    input logic                               cfg_we,
    input logic [cbma_pkg::MIN_W-1:0]         cfg_data
);
    import cbma_pkg::*;

    localparam int PEND_W   = 3;
    localparam int PEND_MAX = QUEUE_DEPTH + 2;

    logic [MIN_W-1:0]         min_reg;
    logic [PEND_W-1:0]        pend_reg;
    logic [PEND_W-1:0]        pend_next;
    logic                     est_acc;
    logic                     out_acc;
    logic signed [TIME_W-1:0] min_ext;

    assign est_acc = in_valid && !in_stall && (func == FUNC_ESTIMATE);
    assign out_acc = out_valid && !out_stall;
    assign min_ext = $signed({{(TIME_W - MIN_W){1'b0}}, min_reg});

    always_comb
    begin
        pend_next = pend_reg;
        if (est_acc && !out_acc)
        begin
            pend_next = pend_reg + 1'b1;
        end
        else if (out_acc && !est_acc)
        begin
            pend_next = pend_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg  <= MIN_RESET;
            pend_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                min_reg <= cfg_data;
            end
            pend_reg <= pend_next;
        end
    end

    `CBMA_ASSERT_NOW(a_floor, out_valid, estimate >= min_ext, "estimate below floor")
    `CBMA_ASSERT_NOW(a_no_spurious, out_valid, pend_reg != '0, "result without estimate request")
    `CBMA_ASSERT_NOW(a_pend_bound, 1'b1, pend_reg <= PEND_W'(PEND_MAX), "too many estimates in flight")
    `CBMA_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(estimate), "stalled result changed")

endmodule

bind class_bucketed_moving_average cbma_checker u_cbma_checker (.*);

FILE: verif/cbma_estimate_checker.sv
// checker for the class bucketed moving average: watches both channels and the config port,
// keeps its own rings and floor, and compares each estimate with the oldest one predicted
// depends on cbma_pkg
module cbma_estimate_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic                               func,
    input  logic [cbma_pkg::PRIO_W-1:0]        priority_req,
    input  logic [cbma_pkg::TIME_W-1:0]        now_time,
    input  logic [cbma_pkg::TIME_W-1:0]        received_time,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic signed [cbma_pkg::TIME_W-1:0] estimate,
    input  logic                               cfg_we,
    input  logic [cbma_pkg::MIN_W-1:0]         cfg_data,
    output int                                 mismatch_count,
    output int                                 estimates_due
);
    import cbma_pkg::*;

    logic signed [TIME_W-1:0] elapsed_ring [CLASS_COUNT][WINDOW_LEN];
    logic [POS_W-1:0]         ring_slot [CLASS_COUNT];
    logic [MIN_W-1:0]         floor_val;
    logic signed [TIME_W-1:0] expected_estimates [$];
    logic signed [TIME_W-1:0] want;
    int                       bucket;

    // priority to class: five single classes, then one class per bound range
    function automatic int bucket_of(input logic [PRIO_W-1:0] p);
        if (p < CLASS_BOUNDS[0])
            return int'(p);
        for (int k = 1; k < BOUND_COUNT; k++)
        begin
            if (p < CLASS_BOUNDS[k])
                return SINGLE_CLASSES + k - 1;
        end
        return CLASS_COUNT - 1;
    endfunction

    // window sum without overflow, divide truncating toward zero, then floor
    function automatic logic signed [TIME_W-1:0] class_average(input int c);
        longint total;
        longint avg;
        total = 0;
        for (int i = 0; i < WINDOW_LEN; i++)
            total += longint'(elapsed_ring[c][i]);
        avg = total / WINDOW_LEN;
        if (avg < longint'(floor_val))
            avg = longint'(floor_val);
        return avg[TIME_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CLASS_COUNT; c++)
            begin
                ring_slot[c] = '0;
                for (int i = 0; i < WINDOW_LEN; i++)
                    elapsed_ring[c][i] = '0;
            end
            floor_val = MIN_RESET;
            expected_estimates.delete();
            mismatch_count = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_estimates.size() == 0)
                begin
                    $error("estimate: unexpected result, actual %0d", estimate);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_estimates.pop_front();
                    if (estimate !== want)
                    begin
                        $error("estimate mismatch: expected %0d, actual %0d", want, estimate);
                        mismatch_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                bucket = bucket_of(priority_req);
                if (func_t'(func) == FUNC_ESTIMATE)
                    expected_estimates.push_back(class_average(bucket));
                else
                begin
                    elapsed_ring[bucket][ring_slot[bucket]] = now_time - received_time;
                    ring_slot[bucket] = (ring_slot[bucket] == POS_W'(WINDOW_LEN - 1)) ?
                                        '0 : ring_slot[bucket] + 1'b1;
                end
            end
            if (cfg_we)
                floor_val = cfg_data;
        end
        estimates_due = expected_estimates.size();
    end

endmodule

FILE: verif/tb_class_bucketed_moving_average.sv
// testbench top for the class bucketed moving average: reset, directed and random requests
// with idle bursts on both channels, floor register changes between phases, and the verdict
// depends on cbma_pkg, class_bucketed_moving_average, cbma_estimate_checker
module tb_class_bucketed_moving_average;
    import cbma_pkg::*;

    localparam int SETTLE_CYCLES = 30;
    localparam int LONG_HOLD     = 400;
    localparam int STALL_LIMIT   = 4000;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    func_t                     func;
    logic [PRIO_W-1:0]         priority_req;
    logic [TIME_W-1:0]         now_time;
    logic [TIME_W-1:0]         received_time;
    logic                      out_valid;
    logic                      out_stall;
    logic signed [TIME_W-1:0]  estimate;
    logic                      cfg_we;
    logic [MIN_W-1:0]          cfg_data;

    int mismatch_count;
    int estimates_due;
    int idle_cycles;
    bit full_rate;
    bit burst_in;
    bit hold_req;

    always #6 clk = ~clk;

    class_bucketed_moving_average dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .priority_req  (priority_req),
        .now_time      (now_time),
        .received_time (received_time),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .estimate      (estimate),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data)
    );

    cbma_estimate_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .priority_req   (priority_req),
        .now_time       (now_time),
        .received_time  (received_time),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .estimate       (estimate),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .estimates_due  (estimates_due)
    );

    // watchdog on cycles with no handshake on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // receiver: stall bursts, run stretches, one long hold on request
    initial
    begin
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (!full_rate && $urandom_range(0, 2) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                repeat (full_rate ? 1 : $urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    task automatic send_request(input func_t f, input logic [PRIO_W-1:0] p,
                                input logic [TIME_W-1:0] now_v, input logic [TIME_W-1:0] rcv_v);
        if (!full_rate && !burst_in && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        func          <= f;
        priority_req  <= p;
        now_time      <= now_v;
        received_time <= rcv_v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (estimates_due != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_floor(input logic [MIN_W-1:0] value);
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_random(input int count);
        func_t             f;
        logic [PRIO_W-1:0] p;
        logic [TIME_W-1:0] rcv;
        logic [TIME_W-1:0] span;
        int                sel;
        for (int n = 0; n < count; n++)
        begin
            f = ($urandom_range(0, 99) < 35) ? FUNC_ESTIMATE : FUNC_RECORD;
            sel = $urandom_range(0, 9);
            if (sel < 4)
                p = PRIO_W'($urandom_range(0, 4));
            else if (sel < 7)
                p = PRIO_W'(CLASS_BOUNDS[$urandom_range(0, BOUND_COUNT - 1)] - 1 +
                            $urandom_range(0, 2));
            else if (sel < 9)
                p = PRIO_W'($urandom());
            else
                p = PRIO_W'($urandom_range(10000, 65535));
            rcv = $urandom();
            sel = $urandom_range(0, 9);
            if (sel < 5)
                span = $urandom_range(0, 2000);
            else if (sel < 7)
                span = $urandom_range(0, 1 << 20);
            else if (sel < 8)
                span = -$urandom_range(1, 500);
            else
                span = $urandom();
            send_request(f, p, rcv + span, rcv);
        end
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        func          <= FUNC_RECORD;
        priority_req  <= '0;
        now_time      <= '0;
        received_time <= '0;
        cfg_we        <= 1'b0;
        cfg_data      <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty ring, then a single record
        send_request(FUNC_ESTIMATE, 16'd0, 32'd0, 32'd0);
        send_request(FUNC_RECORD, 16'd0, 32'd100, 32'd0);
        send_request(FUNC_ESTIMATE, 16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // received after now gives a negative time, floored
        send_request(FUNC_RECORD, 16'd4, 32'd0, 32'd1000);
        send_request(FUNC_ESTIMATE, 16'd4, 32'd0, 32'd0);
        // wrapping differences in the top class
        send_request(FUNC_RECORD, 16'hFFFF, 32'hFFFF_FFFF, 32'd0);
        send_request(FUNC_RECORD, 16'd10000, 32'd0, 32'h8000_0000);
        send_request(FUNC_RECORD, 16'd12345, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_request(FUNC_ESTIMATE, 16'hFFFF, 32'd0, 32'd0);
        // full ring of the largest positive time, position wraps
        for (int i = 0; i < WINDOW_LEN + 1; i++)
            send_request(FUNC_RECORD, 16'd100, 32'h7FFF_FFFF, 32'd0);
        send_request(FUNC_ESTIMATE, 16'd5, 32'd0, 32'd0);
        send_request(FUNC_RECORD, 16'd699, 32'd123, 32'd0);
        send_request(FUNC_ESTIMATE, 16'd101, 32'd0, 32'd0);
        send_request(FUNC_ESTIMATE, 16'd9999, 32'd0, 32'd0);

        write_floor(16'd0);
        run_random(400);

        // receiver holds off while requests keep coming
        hold_req = 1'b1;
        burst_in = 1'b1;
        send_request(FUNC_ESTIMATE, 16'd3, 32'd0, 32'd0);
        run_random(60);
        burst_in = 1'b0;

        write_floor(16'hFFFF);
        run_random(350);
        write_floor(16'($urandom_range(1, 4000)));
        run_random(400);
        write_floor(MIN_RESET);
        full_rate = 1'b1;
        run_random(400);

        wait_drained();
        if (mismatch_count == 0 && estimates_due == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
